>>> design/ptdc_pkg.sv
package ptdc_pkg;

  localparam int unsigned NUM_STAGES = 8;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CAL_W      = 16;

  localparam logic [CAL_W-1:0] SURFACE_RESET = 16'd10133;
  localparam logic signed [18:0] TEMP_BASE   = 19'sd2000;

  // depth: |p - surf| * 100 / 978 == |p - surf| * 50 / 489, exact for n < 2^32
  localparam int unsigned   DEPTH_SHIFT = 41;
  localparam longint unsigned DEPTH_RECIP_L = ((64'd1 << DEPTH_SHIFT) + 64'd488) / 64'd489;
  localparam logic [32:0]   DEPTH_RECIP = DEPTH_RECIP_L[32:0];
  localparam logic [5:0]    DEPTH_SCALE = 6'd50;

  // temperature: |temp| / 10, exact for n < 2^18
  localparam int unsigned   TEMP_SHIFT = 22;
  localparam longint unsigned TEMP_RECIP_L = ((64'd1 << TEMP_SHIFT) + 64'd9) / 64'd10;
  localparam logic [18:0]   TEMP_RECIP = TEMP_RECIP_L[18:0];

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SENS      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SENS_TC   = 3'd2,
    REG_OFFSET_TC = 3'd3,
    REG_REF_TEMP  = 3'd4,
    REG_TEMP_COEF = 3'd5,
    REG_SURFACE   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [CAL_W-1:0] sens;
    logic [CAL_W-1:0] offset;
    logic [CAL_W-1:0] sens_tc;
    logic [CAL_W-1:0] offset_tc;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_coef;
    logic [CAL_W-1:0] surface;
  } cfg_t;

endpackage

>>> design/ptdc_cfg.sv
module ptdc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [ptdc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [ptdc_pkg::CAL_W-1:0]       cfg_data_i,
  output ptdc_pkg::cfg_t                   cfg_o
);
  import ptdc_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_SENS:      cfg_d.sens      = cfg_data_i;
        REG_OFFSET:    cfg_d.offset    = cfg_data_i;
        REG_SENS_TC:   cfg_d.sens_tc   = cfg_data_i;
        REG_OFFSET_TC: cfg_d.offset_tc = cfg_data_i;
        REG_REF_TEMP:  cfg_d.ref_temp  = cfg_data_i;
        REG_TEMP_COEF: cfg_d.temp_coef = cfg_data_i;
        REG_SURFACE:   cfg_d.surface   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= '0;
      cfg_q.surface <= SURFACE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/pressure_temperature_depth_compensation.sv
// First-order pressure sensor compensation: each input item carries a raw pressure
// and a raw temperature word, each result item carries depth in cm and temperature
// in 0.1 degC. The datapath is an eight-stage pipeline (temperature difference,
// three coefficient products, offset/sensitivity, pressure product, pressure and
// surface subtract, magnitude scaling, reciprocal multiply, sign restore), so one
// item is accepted per cycle unless back pressure stalls the pipeline. The width of
// the pressure product and the reciprocal multiply set the stage depth. Back
// pressure only stalls stages that hold an item, so empty stages keep filling while
// the output waits. Calibration writes are always ready and take effect at once;
// write them only while no item is in flight.
module pressure_temperature_depth_compensation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [47:0]                      s_axis_tdata,  // raw_pressure, raw_temperature
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [39:0]                      m_axis_tdata,  // depth, temp_deci_c, zero pad
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ptdc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [ptdc_pkg::CAL_W-1:0]       cfg_data_i
);
  import ptdc_pkg::*;

  cfg_t cfg;

  ptdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  logic [NUM_STAGES-1:0] valid_q, valid_d, stage_en;

  always_comb begin
    stage_en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (stage_en[0]) valid_d[0] = s_axis_tvalid;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (stage_en[k]) valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = stage_en[0];

  // stage 0: temperature difference
  logic [23:0]        d1_s0_d, d1_s0_q;
  logic signed [24:0] dt_d, dt_q;
  // stage 1: coefficient products
  logic [23:0]        d1_s1_q;
  logic signed [41:0] prod_t_d, prod_t_q, prod_o_d, prod_o_q, prod_s_d, prod_s_q;
  // stage 2: temperature, offset, sensitivity
  logic [23:0]        d1_s2_q;
  logic signed [18:0] temp_d, temp_q;
  logic signed [34:0] off_d, off_s2_q, off_s3_q;
  logic signed [33:0] sens_d, sens_q;
  // stage 3: pressure product, temperature magnitude
  logic signed [58:0] pm_d, pm_q;
  logic [17:0]        tabs_d, tabs_q;
  logic               tneg_d, tneg_s3_q, tneg_s4_q, tneg_s5_q, tneg_s6_q;
  // stage 4: pressure minus surface, temperature reciprocal product
  logic signed [38:0] p_full;
  logic signed [25:0] p_w;
  logic signed [26:0] x_d, x_q;
  logic [36:0]        tm_d, tm_q;
  // stage 5: depth magnitude scaling, temperature quotient
  logic [26:0]        xabs;
  logic [31:0]        n_d, n_q;
  logic               dneg_d, dneg_s5_q, dneg_s6_q;
  logic [14:0]        tq_d, tq_s5_q, tq_s6_q;
  // stage 6: depth reciprocal product
  logic [64:0]        dm_d, dm_q;
  // stage 7: results
  logic [23:0]        dq;
  logic [20:0]        depth_d, depth_q;
  logic [14:0]        tdeci_d, tdeci_q;

  always_comb begin
    d1_s0_d = s_axis_tdata[23:0];
    dt_d    = $signed({1'b0, s_axis_tdata[47:24]} - {1'b0, cfg.ref_temp, 8'h00});

    prod_t_d = dt_q * $signed({1'b0, cfg.temp_coef});
    prod_o_d = dt_q * $signed({1'b0, cfg.offset_tc});
    prod_s_d = dt_q * $signed({1'b0, cfg.sens_tc});

    temp_d = TEMP_BASE + 19'(prod_t_q >>> 23);
    off_d  = $signed({3'b000, cfg.offset, 16'h0000}) + 35'(prod_o_q >>> 7);
    sens_d = $signed({3'b000, cfg.sens, 15'h0000}) + 34'(prod_s_q >>> 8);

    pm_d   = $signed({1'b0, d1_s2_q}) * sens_q;
    tneg_d = temp_q[18];
    tabs_d = temp_q[18] ? 18'(-temp_q) : 18'(temp_q);

    p_full = 39'(pm_q >>> 21) - 39'(off_s3_q);
    p_w    = 26'(p_full >>> 13);
    x_d    = 27'(p_w) - $signed({11'h000, cfg.surface});
    tm_d   = 37'(tabs_q) * 37'(TEMP_RECIP);

    xabs   = x_q[26] ? 27'(-x_q) : 27'(x_q);
    n_d    = 32'(xabs) * 32'(DEPTH_SCALE);
    dneg_d = x_q[26];
    tq_d   = 15'(tm_q >> TEMP_SHIFT);

    dm_d = 65'(n_q) * 65'(DEPTH_RECIP);

    dq      = 24'(dm_q >> DEPTH_SHIFT);
    depth_d = dneg_s6_q ? 21'(-dq) : 21'(dq);
    tdeci_d = tneg_s6_q ? 15'(-tq_s6_q) : tq_s6_q;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      d1_s0_q <= d1_s0_d;
      dt_q    <= dt_d;
    end
    if (stage_en[1]) begin
      d1_s1_q  <= d1_s0_q;
      prod_t_q <= prod_t_d;
      prod_o_q <= prod_o_d;
      prod_s_q <= prod_s_d;
    end
    if (stage_en[2]) begin
      d1_s2_q  <= d1_s1_q;
      temp_q   <= temp_d;
      off_s2_q <= off_d;
      sens_q   <= sens_d;
    end
    if (stage_en[3]) begin
      pm_q      <= pm_d;
      off_s3_q  <= off_s2_q;
      tabs_q    <= tabs_d;
      tneg_s3_q <= tneg_d;
    end
    if (stage_en[4]) begin
      x_q       <= x_d;
      tm_q      <= tm_d;
      tneg_s4_q <= tneg_s3_q;
    end
    if (stage_en[5]) begin
      n_q       <= n_d;
      dneg_s5_q <= dneg_d;
      tq_s5_q   <= tq_d;
      tneg_s5_q <= tneg_s4_q;
    end
    if (stage_en[6]) begin
      dm_q      <= dm_d;
      dneg_s6_q <= dneg_s5_q;
      tq_s6_q   <= tq_s5_q;
      tneg_s6_q <= tneg_s5_q;
    end
    if (stage_en[7]) begin
      depth_q <= depth_d;
      tdeci_q <= tdeci_d;
    end
  end

  assign m_axis_tvalid = valid_q[NUM_STAGES-1];
  assign m_axis_tdata  = {4'h0, tdeci_q, depth_q};

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&valid_q))
    else $error("input stalled with a bubble in the pipeline");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> valid_q[0])
    else $error("accepted item did not enter first stage");

  a_held_stage_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_q & ~stage_en) != '0) |=>
      ((valid_q & $past(valid_q & ~stage_en)) == $past(valid_q & ~stage_en)))
    else $error("stalled stage lost its item");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ptdc_pkg::*;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 94;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES = 200000;

  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [23:0] raw_temperature;
    logic [23:0] raw_pressure;
  } raw_item_t;

  typedef struct packed {
    logic [14:0] temp_deci_c;
    logic [20:0] depth;
  } result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata  = '0;  // raw_pressure, raw_temperature
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;        // depth, temp_deci_c, zero pad
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CAL_W-1:0]      cfg_data_i    = '0;

  cfg_t        cal;
  raw_item_t   raw_pending[$];
  result_t     expected_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  logic        in_fast   = 1'b0;
  logic        out_fast  = 1'b0;
  logic        hold_go   = 1'b0;
  logic        hold_armed = 1'b0;
  int unsigned hold_left = 0;
  int unsigned in_wait   = 0;
  int unsigned out_wait  = 0;
  int unsigned in_burst  = 0;
  int unsigned out_burst = 0;

  pressure_temperature_depth_compensation uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic result_t compensate(logic [23:0] d1_raw, logic [23:0] d2_raw, cfg_t c);
    longint d1, d2, c1, c2, c3, c4, c5, c6, surf;
    longint dt, temp, off, sens, p, depth, tdeci;
    result_t r;
    d1   = {40'd0, d1_raw};
    d2   = {40'd0, d2_raw};
    c1   = {48'd0, c.sens};
    c2   = {48'd0, c.offset};
    c3   = {48'd0, c.sens_tc};
    c4   = {48'd0, c.offset_tc};
    c5   = {48'd0, c.ref_temp};
    c6   = {48'd0, c.temp_coef};
    surf = {48'd0, c.surface};
    dt    = d2 - (c5 <<< 8);
    temp  = 2000 + ((dt * c6) >>> 23);
    off   = (c2 <<< 16) + ((c4 * dt) >>> 7);
    sens  = (c1 <<< 15) + ((c3 * dt) >>> 8);
    p     = (((d1 * sens) >>> 21) - off) >>> 13;
    depth = ((p - surf) * 100) / 978;
    tdeci = temp / 10;
    r.depth       = depth[20:0];
    r.temp_deci_c = tdeci[14:0];
    return r;
  endfunction

  function automatic int unsigned pick_wait(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst = $urandom_range(8, 40);
    return $urandom_range(0, 15);
  endfunction

  function automatic raw_item_t random_sample(logic [CAL_W-1:0] ref_temp);
    raw_item_t it;
    int unsigned mode;
    longint t;
    it.raw_pressure    = 24'($urandom);
    it.raw_temperature = 24'($urandom);
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      it.raw_pressure = $urandom_range(0, 1) ? '1 : '0;
    end else if (mode == 1) begin
      it.raw_temperature = $urandom_range(0, 1) ? '1 : '0;
    end else if (mode <= 4) begin
      // temperature close to the reference point
      t = longint'({40'd0, ref_temp, 8'd0}) + longint'($urandom_range(0, 8191)) - 4096;
      if (t < 0) t = 0;
      if (t > 64'hFFFFFF) t = 64'hFFFFFF;
      it.raw_temperature = t[23:0];
    end
    return it;
  endfunction

  function automatic cfg_t random_cal(int unsigned kind);
    cfg_t c;
    c = cfg_t'(112'({$urandom, $urandom, $urandom, $urandom}));
    case (kind)
      1: c = '1;
      2: begin
        c = '0;
        c.surface = 16'($urandom);
      end
      3: begin
        c.sens      = 16'(46372 + $urandom_range(0, 2047) - 1024);
        c.offset    = 16'(43981 + $urandom_range(0, 2047) - 1024);
        c.sens_tc   = 16'(29059 + $urandom_range(0, 2047) - 1024);
        c.offset_tc = 16'(27842 + $urandom_range(0, 2047) - 1024);
        c.ref_temp  = 16'(31553 + $urandom_range(0, 2047) - 1024);
        c.temp_coef = 16'(28165 + $urandom_range(0, 2047) - 1024);
        c.surface   = 16'(10133 + $urandom_range(0, 255) - 128);
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CAL_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SENS:      cal.sens      = val;
      REG_OFFSET:    cal.offset    = val;
      REG_SENS_TC:   cal.sens_tc   = val;
      REG_OFFSET_TC: cal.offset_tc = val;
      REG_REF_TEMP:  cal.ref_temp  = val;
      REG_TEMP_COEF: cal.temp_coef = val;
      REG_SURFACE:   cal.surface   = val;
      default: ;
    endcase
  endtask

  task automatic write_cal(cfg_t v);
    write_reg(REG_SENS, v.sens);
    write_reg(REG_OFFSET, v.offset);
    write_reg(REG_SENS_TC, v.sens_tc);
    write_reg(REG_OFFSET_TC, v.offset_tc);
    write_reg(REG_REF_TEMP, v.ref_temp);
    write_reg(REG_TEMP_COEF, v.temp_coef);
    write_reg(REG_SURFACE, v.surface);
    // out of range index, must leave every register alone
    write_reg(REG_NONE, 16'($urandom));
  endtask

  task automatic queue_corners();
    logic [23:0] zero_dt;
    zero_dt = {cal.ref_temp, 8'd0};
    @(posedge clk_i);
    raw_pending.push_back('{raw_temperature: 24'h000000, raw_pressure: 24'h000000});
    raw_pending.push_back('{raw_temperature: 24'hFFFFFF, raw_pressure: 24'hFFFFFF});
    raw_pending.push_back('{raw_temperature: 24'h000000, raw_pressure: 24'hFFFFFF});
    raw_pending.push_back('{raw_temperature: 24'hFFFFFF, raw_pressure: 24'h000000});
    raw_pending.push_back('{raw_temperature: zero_dt, raw_pressure: 24'h800000});
    raw_pending.push_back('{raw_temperature: zero_dt - 24'd1, raw_pressure: 24'h000001});
  endtask

  task automatic queue_samples(int unsigned n);
    @(posedge clk_i);
    repeat (n) raw_pending.push_back(random_sample(cal.ref_temp));
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (raw_pending.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin : drive_samples
    raw_item_t it;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (in_wait != 0) begin
        s_axis_tvalid <= 1'b0;
        in_wait       <= in_wait - 1;
      end else if (raw_pending.size() != 0) begin
        it = raw_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.raw_temperature, it.raw_pressure};
        in_wait       <= in_fast ? 0 : pick_wait(in_burst);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : hold_results
    if (hold_go && !hold_armed) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    if (!hold_go) hold_armed <= 1'b0;
  end

  always @(negedge clk_i) begin : accept_results
    int unsigned w;
    w = out_wait;
    if (out_taken) w = out_fast ? 0 : pick_wait(out_burst);
    if (!rst_ni || hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (w != 0) begin
      m_axis_tready <= 1'b0;
      w--;
    end else begin
      m_axis_tready <= 1'b1;
    end
    out_wait <= w;
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    logic [20:0] got_depth;
    logic [14:0] got_temp;
    cycle_count++;
    in_taken  <= s_axis_tvalid && s_axis_tready;
    out_taken <= m_axis_tvalid && m_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      got_depth = m_axis_tdata[20:0];
      got_temp  = m_axis_tdata[35:21];
      if (expected_results.size() == 0) begin
        $display("%0t: result item with none expected: depth %0d temp_deci_c %0d",
                 $time, $signed(got_depth), $signed(got_temp));
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got_depth !== want.depth) begin
          $display("%0t: depth expected %0d actual %0d",
                   $time, $signed(want.depth), $signed(got_depth));
          error_count++;
        end
        if (got_temp !== want.temp_deci_c) begin
          $display("%0t: temp_deci_c expected %0d actual %0d",
                   $time, $signed(want.temp_deci_c), $signed(got_temp));
          error_count++;
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready)
      expected_results.push_back(compensate(s_axis_tdata[23:0], s_axis_tdata[47:24], cal));
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : run_phases
    cfg_t c;
    cal = '0;
    cal.surface = SURFACE_RESET;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values first
    queue_corners();
    wait_drained();

    c = random_cal(3);
    write_cal(c);
    queue_corners();
    wait_drained();

    write_cal('1);
    queue_corners();
    wait_drained();

    write_cal('0);
    queue_corners();
    wait_drained();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      write_cal(random_cal(ph % 4));
      if (ph == 2) begin
        // output blocked while the input keeps coming
        @(posedge clk_i);
        in_fast = 1'b1;
        hold_go = 1'b1;
        queue_samples(PHASE_ITEMS);
        wait_drained();
        @(posedge clk_i);
        in_fast = 1'b0;
        hold_go = 1'b0;
      end else if (ph == 5) begin
        queue_samples(PHASE_ITEMS / 2);
        wait_drained();
        queue_samples(PHASE_ITEMS - PHASE_ITEMS / 2);
        wait_drained();
      end else begin
        @(posedge clk_i);
        out_fast = (ph == 6);
        queue_samples(PHASE_ITEMS);
        wait_drained();
      end
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
